// File: rtl/u8v_pkg.sv
// Package for the streaming UTF-8 validator: beat types, byte classes and constants.
// Used by every module in rtl/. Depends on nothing.
package u8v_pkg;

   localparam int OFFSET_WIDTH_DEFAULT = 32;   // width of the internal offset counters
   localparam int BAD_OFFSET_WIDTH     = 32;   // width of the reported offset field
   localparam int QUEUE_DEPTH          = 4;    // entries between classifier and decoder
   localparam int QUEUE_AW             = $clog2(QUEUE_DEPTH);

   localparam int CODE_WIDTH = 21;
   localparam logic [CODE_WIDTH-1:0] CP_MIN_2BYTE  = 21'h000080;
   localparam logic [CODE_WIDTH-1:0] CP_MIN_3BYTE  = 21'h000800;
   localparam logic [CODE_WIDTH-1:0] CP_SURR_LOW   = 21'h00D800;
   localparam logic [CODE_WIDTH-1:0] CP_SURR_HIGH  = 21'h00DFFF;
   localparam logic [CODE_WIDTH-1:0] CP_MIN_4BYTE  = 21'h010000;
   localparam logic [CODE_WIDTH-1:0] CP_MAX        = 21'h10FFFF;

   localparam logic [2:0] SEQ_LEN_NONE = 3'd0;
   localparam logic [2:0] SEQ_LEN_2    = 3'd2;
   localparam logic [2:0] SEQ_LEN_3    = 3'd3;
   localparam logic [2:0] SEQ_LEN_4    = 3'd4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic                        stream_valid;
      logic [BAD_OFFSET_WIDTH-1:0] bad_offset;
   } rsp_type;

   typedef enum logic [2:0] {
      CLS_ASCII,
      CLS_CONT,
      CLS_LEAD2,
      CLS_LEAD3,
      CLS_LEAD4,
      CLS_BAD
   } byte_class_type;

   // One classified byte as it travels through the queue.
   typedef struct packed {
      byte_class_type cls;
      logic [5:0]     bits;       // payload bits of the byte, right aligned
      logic           last_byte;
   } item_type;

endpackage

// File: rtl/utf8_stream_validator.sv
// Top level of the streaming UTF-8 validator: classifier, byte queue and decoder.
// Depends on u8v_pkg, u8v_front, u8v_queue and u8v_back.
//
//   Channel   Direction  Handshake            Beat contents
//   req_      in         req_valid/req_ready  data_byte, last_byte
//   rsp_      out        rsp_valid/rsp_ready  stream_valid, bad_offset
//
// The block takes one byte per cycle for as long as the decoder keeps up, which it
// always does except when a final byte meets a result that has not yet been taken.
// A byte is classified and written into the four-entry queue on the edge at which it
// is accepted; the decoder then takes it from the head of the queue, and the result
// register is loaded on the edge at which the final byte is taken, so a final byte
// passes through a queue entry and then the result register before rsp_valid rises.
// Reset is synchronous: it empties the queue, clears every decoder register and drops
// rsp_valid. A stalled result blocks only the next final byte; the bytes in front of
// it keep flowing until the queue fills, and only then does req_ready fall.
//
// The front end reduces each byte to a class (plain, continuation, lead of a two,
// three or four byte sequence, or invalid lead) plus its payload bits. The back end
// tracks the open sequence, builds the code point, rejects overlong forms, surrogates
// and values above the Unicode range, and keeps the saturating byte offset. Only the
// first error of a stream is reported; a stream is judged on its final byte, after
// which all decoder state returns to its reset value for the next stream.
module utf8_stream_validator #(
   parameter int OFFSET_WIDTH = u8v_pkg::OFFSET_WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  u8v_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output u8v_pkg::rsp_type rsp_data
);
   import u8v_pkg::*;

   logic     push_valid, push_ready;
   item_type push_data;
   logic     pop_valid, pop_ready;
   item_type pop_data;

   u8v_front u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   u8v_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   u8v_back #(
      .OFFSET_WIDTH (OFFSET_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// File: rtl/u8v_front.sv
// Front end of the UTF-8 validator: accepts input beats and classifies each byte.
// Depends on u8v_pkg.
module u8v_front (
   input  logic              req_valid,
   output logic              req_ready,
   input  u8v_pkg::req_type  req_data,
   output logic              push_valid,
   input  logic              push_ready,
   output u8v_pkg::item_type push_data
);
   import u8v_pkg::*;

   logic [7:0] b;

   assign b          = req_data.data_byte;
   assign req_ready  = push_ready;
   assign push_valid = req_valid;

   always_comb begin
      push_data.last_byte = req_data.last_byte;
      push_data.bits      = b[5:0];
      unique case (b) inside
         [8'h00:8'h7F]: begin
            push_data.cls = CLS_ASCII;
         end
         [8'h80:8'hBF]: begin
            push_data.cls = CLS_CONT;
         end
         [8'hC0:8'hDF]: begin
            push_data.cls  = CLS_LEAD2;
            push_data.bits = {1'b0, b[4:0]};
         end
         [8'hE0:8'hEF]: begin
            push_data.cls  = CLS_LEAD3;
            push_data.bits = {2'b00, b[3:0]};
         end
         [8'hF0:8'hF7]: begin
            push_data.cls  = CLS_LEAD4;
            push_data.bits = {3'b000, b[2:0]};
         end
         default: begin
            push_data.cls = CLS_BAD;
         end
      endcase
   end

endmodule

// File: rtl/u8v_queue.sv
// Small first-word-fall-through queue of classified bytes between front and back end.
// Depends on u8v_pkg.
module u8v_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  u8v_pkg::item_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output u8v_pkg::item_type pop_data
);
   import u8v_pkg::*;

   item_type            entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   count_ff,  count_in;
   logic                push, pop;

   localparam logic [QUEUE_AW:0] FULL_COUNT = (QUEUE_AW+1)'(QUEUE_DEPTH);
   localparam logic [QUEUE_AW-1:0] LAST_PTR = QUEUE_AW'(QUEUE_DEPTH - 1);

   assign push_ready = (count_ff != FULL_COUNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // The fill count must never run past the number of entries.
   assert property (@(posedge clock) disable iff (reset) count_ff <= FULL_COUNT)
      else $error("queue count exceeds depth");

   // Pointers and count must agree: equal pointers mean empty or full.
   assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff == rd_ptr_ff) |-> (count_ff == '0 || count_ff == FULL_COUNT))
      else $error("queue pointers disagree with count");

endmodule

// File: rtl/u8v_back.sv
// Back end of the UTF-8 validator: sequence decoder, offset counters and result register.
// Depends on u8v_pkg.
module u8v_back #(
   parameter int OFFSET_WIDTH = u8v_pkg::OFFSET_WIDTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  u8v_pkg::item_type pop_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output u8v_pkg::rsp_type  rsp_data
);
   import u8v_pkg::*;

   localparam logic [OFFSET_WIDTH-1:0] OFFSET_MAX = '1;

   logic [1:0]              pending_ff,   pending_in;
   logic [2:0]              seq_len_ff,   seq_len_in;
   logic [CODE_WIDTH-1:0]   code_ff,      code_in;
   logic [OFFSET_WIDTH-1:0] pos_ff,       pos_in;
   logic [OFFSET_WIDTH-1:0] seq_start_ff, seq_start_in;
   logic                    err_ff,       err_in;
   logic [OFFSET_WIDTH-1:0] err_pos_ff,   err_pos_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff,  rsp_data_in;

   logic                    take;
   logic                    fail;
   logic [OFFSET_WIDTH-1:0] fail_at;
   logic [CODE_WIDTH-1:0]   code_next;
   logic                    cp_bad;
   logic                    trunc;

   // A non-final byte never touches the result register, so it may pass a
   // result that is still waiting.
   assign pop_ready = !pop_data.last_byte || !rsp_valid_ff || rsp_ready;
   assign take      = pop_valid && pop_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign code_next = {code_ff[CODE_WIDTH-7:0], pop_data.bits};

   always_comb begin
      unique case (seq_len_ff)
         SEQ_LEN_2: cp_bad = code_next < CP_MIN_2BYTE;
         SEQ_LEN_3: cp_bad = (code_next < CP_MIN_3BYTE) ||
                             (code_next >= CP_SURR_LOW && code_next <= CP_SURR_HIGH);
         SEQ_LEN_4: cp_bad = (code_next < CP_MIN_4BYTE) || (code_next > CP_MAX);
         default:   cp_bad = 1'b0;
      endcase
   end

   always_comb begin
      pending_in   = pending_ff;
      seq_len_in   = seq_len_ff;
      code_in      = code_ff;
      seq_start_in = seq_start_ff;
      err_in       = err_ff;
      err_pos_in   = err_pos_ff;
      pos_in       = pos_ff;
      fail         = 1'b0;
      fail_at      = seq_start_ff;
      trunc        = 1'b0;
      rsp_data_in  = rsp_data_ff;

      if (take) begin
         // Once an error is recorded, bytes are only counted.
         if (!err_ff) begin
            if (pending_ff != 2'd0) begin
               if (pop_data.cls != CLS_CONT) begin
                  fail = 1'b1;
               end else begin
                  code_in    = code_next;
                  pending_in = pending_ff - 2'd1;
                  if (pending_ff == 2'd1) begin
                     if (cp_bad) begin
                        fail = 1'b1;
                     end else begin
                        seq_len_in = SEQ_LEN_NONE;
                        code_in    = '0;
                     end
                  end
               end
            end else begin
               unique case (pop_data.cls)
                  CLS_ASCII: begin
                  end
                  CLS_LEAD2: begin
                     seq_len_in   = SEQ_LEN_2;
                     pending_in   = 2'd1;
                     code_in      = CODE_WIDTH'(pop_data.bits[4:0]);
                     seq_start_in = pos_ff;
                  end
                  CLS_LEAD3: begin
                     seq_len_in   = SEQ_LEN_3;
                     pending_in   = 2'd2;
                     code_in      = CODE_WIDTH'(pop_data.bits[3:0]);
                     seq_start_in = pos_ff;
                  end
                  CLS_LEAD4: begin
                     seq_len_in   = SEQ_LEN_4;
                     pending_in   = 2'd3;
                     code_in      = CODE_WIDTH'(pop_data.bits[2:0]);
                     seq_start_in = pos_ff;
                  end
                  default: begin
                     fail    = 1'b1;
                     fail_at = pos_ff;
                  end
               endcase
            end
         end

         if (fail) begin
            err_in     = 1'b1;
            err_pos_in = fail_at;
            pending_in = 2'd0;
            seq_len_in = SEQ_LEN_NONE;
            code_in    = '0;
         end

         if (pos_ff != OFFSET_MAX) begin
            pos_in = pos_ff + 1'b1;
         end

         if (pop_data.last_byte) begin
            // A sequence still open at the end of the stream is truncated.
            trunc                   = !err_in && (pending_in != 2'd0);
            rsp_data_in.stream_valid = !(err_in || trunc);
            if (trunc) begin
               rsp_data_in.bad_offset = BAD_OFFSET_WIDTH'(seq_start_in);
            end else if (err_in) begin
               rsp_data_in.bad_offset = BAD_OFFSET_WIDTH'(err_pos_in);
            end else begin
               rsp_data_in.bad_offset = BAD_OFFSET_WIDTH'(pos_in);
            end
            pending_in   = 2'd0;
            seq_len_in   = SEQ_LEN_NONE;
            code_in      = '0;
            pos_in       = '0;
            seq_start_in = '0;
            err_in       = 1'b0;
            err_pos_in   = '0;
         end
      end
   end

   always_comb begin
      if (take && pop_data.last_byte) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= '0;
         seq_len_ff   <= SEQ_LEN_NONE;
         code_ff      <= '0;
         pos_ff       <= '0;
         seq_start_ff <= '0;
         err_ff       <= 1'b0;
         err_pos_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pending_ff   <= pending_in;
         seq_len_ff   <= seq_len_in;
         code_ff      <= code_in;
         pos_ff       <= pos_in;
         seq_start_ff <= seq_start_in;
         err_ff       <= err_in;
         err_pos_ff   <= err_pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // After an error no sequence may stay open.
   assert property (@(posedge clock) disable iff (reset) err_ff |-> (pending_ff == 2'd0))
      else $error("open sequence after error");

   // The count of outstanding continuation bytes is tied to the sequence length.
   assert property (@(posedge clock) disable iff (reset)
      (pending_ff != 2'd0) |-> (seq_len_ff > {1'b0, pending_ff}))
      else $error("pending count does not fit sequence length");

   // A final byte taken while a result waits unsent would overwrite that result.
   assert property (@(posedge clock) disable iff (reset)
      (take && pop_data.last_byte && rsp_valid_ff) |-> rsp_ready)
      else $error("result overwritten before delivery");

endmodule
